>>> rtl/fost_pkg.sv
// shared constants, types and helpers for the frequency ordered search table
package fost_pkg;

  localparam int DEPTH      = 1024;
  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 32;
  localparam int SLOT_W     = 10;
  localparam int CFG_W      = 11;
  localparam int INDEX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIMIT_W    = INDEX_W + 1;
  localparam int GROUP      = (DEPTH < 32) ? DEPTH : 32;
  localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic [SLOT_W-1:0]       slot;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_RESOLVE,
    ST_COMPARE,
    ST_MOVE,
    ST_FINISH
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic               load;
    logic [INDEX_W-1:0] slot_idx;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count_new;
    logic [INDEX_W-1:0] pos;
    logic [LIMIT_W-1:0] limit;
    logic               do_match;
    logic               do_compare;
    logic               do_move;
  } bcast_t;

  // per group summary back to the sequencer
  typedef struct packed {
    logic               any;
    logic [COUNT_W-1:0] first_cnt;
    logic [INDEX_W-1:0] first_idx;
    logic               all_pass;
    logic               land_any;
    logic [INDEX_W-1:0] land_idx;
  } grp_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    if (&v) return v;
    return v + COUNT_W'(1);
  endfunction

endpackage

>>> rtl/fost_cell.sv
// one table slot: key, access count, match and reorder flags, neighbor shift
module fost_cell (
  input  logic                        clk,
  input  logic [fost_pkg::INDEX_W-1:0] cell_idx,
  input  fost_pkg::bcast_t            bc,
  input  logic [fost_pkg::KEY_W-1:0]   prev_key,
  input  logic [fost_pkg::COUNT_W-1:0] prev_count,
  input  logic                        prev_moves,
  input  logic                        below_in,
  input  logic                        suf_in,
  output logic [fost_pkg::KEY_W-1:0]   key,
  output logic [fost_pkg::COUNT_W-1:0] count,
  output logic                        moves,
  output logic                        below_out,
  output logic                        suf_out,
  output logic                        first,
  output logic                        land,
  output logic                        passable
);

  logic hit;

  assign below_out = below_in | hit;
  assign first     = hit & ~below_in;
  assign suf_out   = passable & suf_in;
  assign moves     = (cell_idx < bc.pos) & suf_out;
  assign land      = (moves | (cell_idx == bc.pos)) & ~prev_moves;

  always_ff @(posedge clk) begin
    if (bc.load && (bc.slot_idx == cell_idx)) begin
      key   <= bc.key;
      count <= '0;
    end else if (bc.do_move) begin
      if (land) begin
        key   <= bc.key;
        count <= bc.count_new;
      end else if (prev_moves) begin
        key   <= prev_key;
        count <= prev_count;
      end
    end
    if (bc.do_match) begin
      hit <= (key == bc.key) && ({1'b0, cell_idx} < bc.limit);
    end
    if (bc.do_compare) begin
      passable <= (cell_idx >= bc.pos) || (count < bc.count_new);
    end
  end

endmodule

>>> rtl/fost_group.sv
// a run of neighboring cells with first-match and landing-slot summaries
module fost_group (
  input  logic                         clk,
  input  logic [fost_pkg::INDEX_W-1:0] base_idx,
  input  fost_pkg::bcast_t             bc,
  input  logic                         suf_in,
  input  logic [fost_pkg::KEY_W-1:0]   prev_key,
  input  logic [fost_pkg::COUNT_W-1:0] prev_count,
  input  logic                         prev_moves,
  output logic [fost_pkg::KEY_W-1:0]   last_key,
  output logic [fost_pkg::COUNT_W-1:0] last_count,
  output logic                         last_moves,
  output fost_pkg::grp_t               status
);

  localparam int G = fost_pkg::GROUP;

  logic [fost_pkg::KEY_W-1:0]   key_v   [G];
  logic [fost_pkg::COUNT_W-1:0] count_v [G];
  logic [fost_pkg::INDEX_W-1:0] idx_v   [G];
  logic [G-1:0]                 moves_v;
  logic [G-1:0]                 first_v;
  logic [G-1:0]                 land_v;
  logic [G-1:0]                 pass_v;
  logic [G:0]                   below_c;
  logic [G:0]                   suf_c;

  assign below_c[0] = 1'b0;
  assign suf_c[G]   = suf_in;

  for (genvar c = 0; c < G; c++) begin : g_cell
    logic [fost_pkg::KEY_W-1:0]   pk;
    logic [fost_pkg::COUNT_W-1:0] pc;
    logic                         pm;

    assign idx_v[c] = base_idx + fost_pkg::INDEX_W'(c);

    if (c == 0) begin : g_head
      assign pk = prev_key;
      assign pc = prev_count;
      assign pm = prev_moves;
    end else begin : g_body
      assign pk = key_v[c-1];
      assign pc = count_v[c-1];
      assign pm = moves_v[c-1];
    end

    fost_cell u_cell (
      .clk       (clk),
      .cell_idx  (idx_v[c]),
      .bc        (bc),
      .prev_key  (pk),
      .prev_count(pc),
      .prev_moves(pm),
      .below_in  (below_c[c]),
      .suf_in    (suf_c[c+1]),
      .key       (key_v[c]),
      .count     (count_v[c]),
      .moves     (moves_v[c]),
      .below_out (below_c[c+1]),
      .suf_out   (suf_c[c]),
      .first     (first_v[c]),
      .land      (land_v[c]),
      .passable  (pass_v[c])
    );
  end

  assign last_key   = key_v[G-1];
  assign last_count = count_v[G-1];
  assign last_moves = moves_v[G-1];

  always_comb begin
    status           = '0;
    status.any       = below_c[G];
    status.all_pass  = &pass_v;
    status.land_any  = |land_v;
    for (int c = 0; c < G; c++) begin
      status.first_cnt = status.first_cnt | (first_v[c] ? count_v[c] : '0);
      status.first_idx = status.first_idx | (first_v[c] ? idx_v[c] : '0);
      status.land_idx  = status.land_idx | (land_v[c] ? idx_v[c] : '0);
    end
  end

endmodule

>>> rtl/frequency_ordered_search_table.sv
// top level: command port, sequencer and the row of table cells
// results: a load is written at its accept edge and gives no word; a search that misses
// gives its word after match, select, resolve; a hit after compare, move and finish as well
// throughput: one load per cycle while idle; a search holds busy, taking no new request,
// through the two-level first-match select and one-step neighbor shift of the cell row
// reset: sequencer idle, entries_in_use 0; table contents undefined until loaded
module frequency_ordered_search_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  fost_pkg::request_t         request,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fost_pkg::CFG_W-1:0] cfg_data,
  output logic                       done,
  output fost_pkg::result_t          result
);

  localparam int NG = fost_pkg::NUM_GROUPS;

  fost_pkg::state_t             state;
  fost_pkg::state_t             state_next;
  fost_pkg::bcast_t             bc;
  logic [fost_pkg::CFG_W-1:0]   entries_in_use;
  logic [fost_pkg::KEY_W-1:0]   skey;
  logic [fost_pkg::INDEX_W-1:0] pos;
  logic [fost_pkg::COUNT_W-1:0] count_new;
  logic                         accept;
  logic                         slot_ok;
  logic [fost_pkg::LIMIT_W-1:0] limit;

  fost_pkg::grp_t               grp_stat [NG];
  logic [fost_pkg::KEY_W-1:0]   grp_key  [NG];
  logic [fost_pkg::COUNT_W-1:0] grp_cnt_last [NG];
  logic [NG-1:0]                grp_moves;
  logic [NG:0]                  grp_suf;

  logic [NG-1:0]                g_any;
  logic [fost_pkg::COUNT_W-1:0] g_cnt  [NG];
  logic [fost_pkg::INDEX_W-1:0] g_idx  [NG];
  logic [NG-1:0]                g_land;
  logic [fost_pkg::INDEX_W-1:0] g_land_idx [NG];

  logic                         hit_any;
  logic [fost_pkg::COUNT_W-1:0] sel_cnt;
  logic [fost_pkg::INDEX_W-1:0] sel_idx;
  logic [fost_pkg::INDEX_W-1:0] land_pos;

  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;
  assign slot_ok   = 32'(request.slot) < 32'(fost_pkg::DEPTH);
  assign limit     = (32'(entries_in_use) > 32'(fost_pkg::DEPTH)) ?
                     fost_pkg::LIMIT_W'(fost_pkg::DEPTH) :
                     fost_pkg::LIMIT_W'(entries_in_use);

  // cell row
  assign grp_suf[NG] = 1'b1;
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [fost_pkg::KEY_W-1:0]   pk;
    logic [fost_pkg::COUNT_W-1:0] pc;
    logic                         pm;

    if (g == 0) begin : g_first
      assign pk = '0;
      assign pc = '0;
      assign pm = 1'b0;
    end else begin : g_rest
      assign pk = grp_key[g-1];
      assign pc = grp_cnt_last[g-1];
      assign pm = grp_moves[g-1];
    end

    assign grp_suf[g] = grp_suf[g+1] & grp_stat[g].all_pass;

    fost_group u_group (
      .clk       (clk),
      .base_idx  (fost_pkg::INDEX_W'(g * fost_pkg::GROUP)),
      .bc        (bc),
      .suf_in    (grp_suf[g+1]),
      .prev_key  (pk),
      .prev_count(pc),
      .prev_moves(pm),
      .last_key  (grp_key[g]),
      .last_count(grp_cnt_last[g]),
      .last_moves(grp_moves[g]),
      .status    (grp_stat[g])
    );
  end

  // lowest group with a match, and the landing slot
  always_comb begin
    logic lower;
    lower    = 1'b0;
    sel_cnt  = '0;
    sel_idx  = '0;
    land_pos = '0;
    for (int g = 0; g < NG; g++) begin
      if (g_any[g] && !lower) begin
        sel_cnt = g_cnt[g];
        sel_idx = g_idx[g];
      end
      lower    = lower | g_any[g];
      land_pos = land_pos | (g_land[g] ? g_land_idx[g] : '0);
    end
    hit_any = lower;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fost_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fost_pkg::ST_IDLE: begin
        if (accept && (request.action == fost_pkg::ACT_SEARCH)) begin
          state_next = fost_pkg::ST_MATCH;
        end
      end
      fost_pkg::ST_MATCH:   state_next = fost_pkg::ST_SELECT;
      fost_pkg::ST_SELECT:  state_next = fost_pkg::ST_RESOLVE;
      fost_pkg::ST_RESOLVE: state_next = hit_any ? fost_pkg::ST_COMPARE : fost_pkg::ST_IDLE;
      fost_pkg::ST_COMPARE: state_next = fost_pkg::ST_MOVE;
      fost_pkg::ST_MOVE:    state_next = fost_pkg::ST_FINISH;
      fost_pkg::ST_FINISH:  state_next = fost_pkg::ST_IDLE;
      default:              state_next = fost_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != fost_pkg::ST_IDLE);
    bc            = '0;
    bc.load       = accept && (request.action == fost_pkg::ACT_LOAD) && slot_ok;
    bc.slot_idx   = fost_pkg::INDEX_W'(request.slot);
    bc.key        = (state == fost_pkg::ST_IDLE) ? unsigned'(request.key) : skey;
    bc.count_new  = count_new;
    bc.pos        = pos;
    bc.limit      = limit;
    bc.do_match   = (state == fost_pkg::ST_MATCH);
    bc.do_compare = (state == fost_pkg::ST_COMPARE);
    bc.do_move    = (state == fost_pkg::ST_MOVE);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && (request.action == fost_pkg::ACT_SEARCH)) begin
      skey <= unsigned'(request.key);
    end
    if (state == fost_pkg::ST_SELECT) begin
      for (int g = 0; g < NG; g++) begin
        g_any[g] <= grp_stat[g].any;
        g_cnt[g] <= grp_stat[g].first_cnt;
        g_idx[g] <= grp_stat[g].first_idx;
      end
    end
    if (state == fost_pkg::ST_RESOLVE) begin
      pos       <= sel_idx;
      count_new <= fost_pkg::sat_inc(sel_cnt);
    end
    if (state == fost_pkg::ST_MOVE) begin
      for (int g = 0; g < NG; g++) begin
        g_land[g]     <= grp_stat[g].land_any;
        g_land_idx[g] <= grp_stat[g].land_idx;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == fost_pkg::ST_RESOLVE) && !hit_any) ||
              (state == fost_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == fost_pkg::ST_RESOLVE) begin
      result.found    <= 1'b0;
      result.position <= '0;
    end else if (state == fost_pkg::ST_FINISH) begin
      result.found    <= 1'b1;
      result.position <= fost_pkg::SLOT_W'(land_pos);
    end
  end

endmodule

>>> rtl/fost_checker.sv
// port-level checks for the frequency ordered search table, bound to the top level
module fost_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input fost_pkg::request_t         request,
  input logic                       done,
  input fost_pkg::result_t          result
);

  logic search_acc;
  logic load_acc;

  assign search_acc = start && !busy && (request.action == fost_pkg::ACT_SEARCH);
  assign load_acc   = start && !busy && (request.action == fost_pkg::ACT_LOAD);

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    search_acc |=> busy)
    else $error("search accepted but block not busy");

  a_search_no_early_word: assert property (@(posedge clk) disable iff (rst)
    search_acc |=> !done)
    else $error("word right after search accept");

  a_load_stays_free: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> !busy)
    else $error("load made the block busy");

  a_word_when_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("word shown while busy");

  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.position == '0))
    else $error("miss word with nonzero position");

endmodule

bind frequency_ordered_search_table fost_checker u_fost_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);
